// ===== hw/rtl/eqst_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types.
package eqst_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int TIMER_SLOTS = 8;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam int CMD_W      = 3;
    localparam int EV_W       = 8;
    localparam int DUR_W      = 16;
    localparam int ID_W       = 8;
    localparam int STEP_W     = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCHED   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNSCHED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

    localparam logic [ID_W-1:0] ID_WRAP  = 8'd255;
    localparam logic [ID_W-1:0] ID_FIRST = 8'd1;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd1;

    typedef struct packed {
        logic latch;
        logic exec;
        logic step;
        logic publish;
    } t_dp_ctl;

    typedef struct packed {
        logic need_scan;
        logic scan_end;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/eqst_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
module eqst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  eqst_pkg::t_dp_sts i_sts,
    output eqst_pkg::t_dp_ctl o_ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_ctl         = '0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_ctl.exec = 1'b1;
                n_state    = i_sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_ctl.step = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/eqst_dp.sv =====
// Datapath with the event FIFO, the timer table, the id counter and the output register.
module eqst_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [eqst_pkg::STEP_W-1:0]         i_cfg_data,
    input  logic [eqst_pkg::CMD_W-1:0]          i_cmd,
    input  logic [eqst_pkg::EV_W-1:0]           i_event_code,
    input  logic [eqst_pkg::DUR_W-1:0]          i_duration,
    input  logic [eqst_pkg::ID_W-1:0]           i_timer_id,
    input  eqst_pkg::t_dp_ctl                   i_ctl,
    output eqst_pkg::t_dp_sts                   o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [eqst_pkg::OUT_DATA_W-1:0]     o_out_data
);

    logic [eqst_pkg::CMD_W-1:0]  r_cmd;
    logic [eqst_pkg::EV_W-1:0]   r_ev;
    logic [eqst_pkg::DUR_W-1:0]  r_dur;
    logic [eqst_pkg::ID_W-1:0]   r_tid;
    logic [eqst_pkg::STEP_W-1:0] r_step;

    logic [eqst_pkg::EV_W-1:0]   r_fifo [eqst_pkg::QUEUE_DEPTH];
    logic [eqst_pkg::QW-1:0]     r_head;
    logic [eqst_pkg::QW-1:0]     r_tail;
    logic [eqst_pkg::CW-1:0]     r_count;

    logic [eqst_pkg::TIMER_SLOTS-1:0] r_act;
    logic [eqst_pkg::DUR_W-1:0]  r_rem   [eqst_pkg::TIMER_SLOTS];
    logic [eqst_pkg::EV_W-1:0]   r_tev   [eqst_pkg::TIMER_SLOTS];
    logic [eqst_pkg::ID_W-1:0]   r_ident [eqst_pkg::TIMER_SLOTS];
    logic [eqst_pkg::ID_W-1:0]   r_id_ctr;
    logic [eqst_pkg::SW-1:0]     r_slot;

    logic [eqst_pkg::EV_W-1:0]   r_res_ev;
    logic [eqst_pkg::ID_W-1:0]   r_res_id;
    logic                        r_res_done;
    logic                        r_out_valid;
    logic [eqst_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                        fifo_room;
    logic                        fifo_empty;
    logic                        slot_act;
    logic [eqst_pkg::ID_W-1:0]   next_id;
    logic                        sched_hit;
    logic                        unsch_hit;
    logic                        expire;
    logic                        push_run;
    logic                        push_tick;
    logic                        fifo_wr;
    logic [eqst_pkg::EV_W-1:0]   fifo_wdata;
    logic                        pop;
    logic                        slot_last;

    assign fifo_room  = r_count < eqst_pkg::CW'(eqst_pkg::QUEUE_DEPTH);
    assign fifo_empty = r_count == '0;
    assign slot_act   = r_act[r_slot];
    assign slot_last  = r_slot == eqst_pkg::SW'(eqst_pkg::TIMER_SLOTS - 1);
    assign next_id    = (r_id_ctr == eqst_pkg::ID_WRAP - 8'd1) ? eqst_pkg::ID_FIRST
                                                                 : r_id_ctr + 8'd1;

    assign sched_hit = (r_cmd == eqst_pkg::CMD_SCHED) && !slot_act;
    assign unsch_hit = (r_cmd == eqst_pkg::CMD_UNSCHED) && slot_act && (r_tid != '0)
                       && (r_ident[r_slot] == r_tid);
    assign expire    = (r_cmd == eqst_pkg::CMD_TICK) && slot_act && (r_rem[r_slot] <= r_step);

    assign push_run   = i_ctl.exec && (r_cmd == eqst_pkg::CMD_PUSH) && (r_ev != '0) && fifo_room;
    assign push_tick  = i_ctl.step && expire && (r_tev[r_slot] != '0) && fifo_room;
    assign fifo_wr    = push_run || push_tick;
    assign fifo_wdata = push_run ? r_ev : r_tev[r_slot];
    assign pop        = i_ctl.exec && (r_cmd == eqst_pkg::CMD_POP) && !fifo_empty;

    assign o_sts.need_scan = (r_cmd == eqst_pkg::CMD_SCHED) || (r_cmd == eqst_pkg::CMD_UNSCHED)
                             || (r_cmd == eqst_pkg::CMD_TICK);
    assign o_sts.scan_end  = sched_hit || unsch_hit || slot_last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (fifo_wr) begin
            r_fifo[r_tail] <= fifo_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= eqst_pkg::STEP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_act       <= '0;
            r_id_ctr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (fifo_wr) begin
                r_tail  <= (r_tail == eqst_pkg::QW'(eqst_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end else if (pop) begin
                r_head  <= (r_head == eqst_pkg::QW'(eqst_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (i_ctl.step) begin
                if (sched_hit) begin
                    r_act[r_slot] <= 1'b1;
                    r_id_ctr      <= next_id;
                end else if (unsch_hit || expire) begin
                    r_act[r_slot] <= 1'b0;
                end
            end
            if (i_ctl.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd      <= i_cmd;
            r_ev       <= i_event_code;
            r_dur      <= i_duration;
            r_tid      <= i_timer_id;
            r_slot     <= '0;
            r_res_ev   <= '0;
            r_res_id   <= '0;
            r_res_done <= 1'b0;
        end
        if (i_ctl.exec) begin
            if (push_run) begin
                r_res_done <= 1'b1;
            end
            if (pop) begin
                r_res_ev <= r_fifo[r_head];
            end
        end
        if (i_ctl.step) begin
            if (!o_sts.scan_end) begin
                r_slot <= r_slot + 1'b1;
            end
            if (sched_hit) begin
                r_rem[r_slot]   <= r_dur;
                r_tev[r_slot]   <= r_ev;
                r_ident[r_slot] <= next_id;
                r_res_id        <= next_id;
                r_res_done      <= 1'b1;
            end else if (unsch_hit) begin
                r_res_done <= 1'b1;
            end else if ((r_cmd == eqst_pkg::CMD_TICK) && slot_act && !expire) begin
                r_rem[r_slot] <= r_rem[r_slot] - r_step;
            end
        end
        if (i_ctl.publish) begin
            r_out_data <= {7'd0, r_res_done, r_res_id, r_res_ev};
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= eqst_pkg::CW'(eqst_pkg::QUEUE_DEPTH))
        else $error("FIFO count exceeds its depth.");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_ctr != eqst_pkg::ID_WRAP)
        else $error("Id counter reached the wrap value.");

    a_active_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_act |-> (r_ident[r_slot] != '0))
        else $error("An active timer slot holds id zero.");

    a_wr_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_wr && pop))
        else $error("FIFO written and popped in the same cycle.");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.publish |=> r_out_valid)
        else $error("Published item did not reach the output register.");
`endif

endmodule

// ===== hw/rtl/event_queue_with_software_timers.sv =====
// Top level of the event queue with software timers.
// An item is accepted at s_axis and gives exactly one result item at m_axis. Push, pop and
// unknown commands pass through the RUN state and then load the result register in DONE once
// the output register is free. Schedule, unschedule and tick walk the timer table one slot per
// cycle in the SCAN state, up to TIMER_SLOTS slots, between RUN and DONE. The walk of the timer
// table sets the rate. One item is worked on at a time, and a new item is accepted while the
// previous result still waits in the output register. The tick step register resets to 1 and
// is written through the cfg channel, which is always ready.
module event_queue_with_software_timers (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // event_code [7:0], duration [23:8], timer_id [31:24]
    input  logic [eqst_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd [2:0]
    input  logic [eqst_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // event_out [7:0], timer_id_out [15:8], done_res [16], zero padding [23:17]
    output logic [eqst_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [eqst_pkg::STEP_W-1:0]         i_cfg_data
);

    eqst_pkg::t_dp_ctl ctl;
    eqst_pkg::t_dp_sts sts;
    logic              cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    eqst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    eqst_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_wr),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (s_axis_tuser),
        .i_event_code (s_axis_tdata[7:0]),
        .i_duration   (s_axis_tdata[23:8]),
        .i_timer_id   (s_axis_tdata[31:24]),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata)
    );

endmodule
